@@ rtl/core/mp3s2_pkg.sv @@
// Shared types and constants for the 3x3 stride-2 max pooling unit.
`timescale 1ns / 1ps
`default_nettype none

package mp3s2_pkg;

    localparam int DATA_W      = 64;
    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 5;
    localparam int GRP_W       = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] HEIGHT_RESET = 6'd27;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 6'd27;
    localparam logic [CFG_W-1:0] GROUPS_RESET = 6'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_HEIGHT      = 2'd0,
        CFG_IN_WIDTH       = 2'd1,
        CFG_CHANNEL_GROUPS = 2'd2
    } cfg_index_t;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [DATA_W-1:0] pixels;
        logic [COL_W-1:0]  col;
        logic [GRP_W-1:0]  grp;
        logic              emit;
        logic              frame_last;
    } desc_t;

endpackage

`default_nettype wire

@@ rtl/core/mp3s2_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mp3s2_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire             aclk,
    input  wire             wr_en,
    input  wire [AW-1:0]    wr_addr,
    input  wire [WIDTH-1:0] wr_data,
    input  wire             rd_en,
    input  wire [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/mp3s2_front.sv @@
// Front end: configuration registers, position counters and item classification.
`timescale 1ns / 1ps
`default_nettype none

module mp3s2_front
    import mp3s2_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_GROUPS = 32
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_wr_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire [DATA_W-1:0]     s_pixels,
    output logic                 q_valid,
    input  wire                  q_ready,
    output desc_t                q_desc
);

    localparam int WMAX = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;

    logic [CFG_W-1:0] height_reg, width_reg, groups_reg;
    logic [CFG_W-1:0] height_eff, width_eff, groups_eff;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic             cfg_hit;
    logic             accept;
    logic             last_grp, last_col, last_row;

    // Out-of-range register values are clamped, zero reads as one.
    always_comb begin
        height_eff = height_reg;
        if (height_reg == '0) begin
            height_eff = CFG_W'(1);
        end else if (height_reg > CFG_W'(32)) begin
            height_eff = CFG_W'(32);
        end
        width_eff = width_reg;
        if (width_reg == '0) begin
            width_eff = CFG_W'(1);
        end else if (width_reg > CFG_W'(WMAX)) begin
            width_eff = CFG_W'(WMAX);
        end
        groups_eff = groups_reg;
        if (groups_reg == '0) begin
            groups_eff = CFG_W'(1);
        end else if ({1'b0, groups_reg} > (CFG_W + 1)'(MAX_GROUPS)) begin
            groups_eff = CFG_W'(MAX_GROUPS);
        end
    end

    always_comb begin
        unique case (cfg_index_t'(cfg_index))
            CFG_IN_HEIGHT, CFG_IN_WIDTH, CFG_CHANNEL_GROUPS: cfg_hit = cfg_wr_en;
            default: cfg_hit = 1'b0;
        endcase
    end

    assign accept   = s_valid && q_ready;
    assign s_ready  = q_ready;
    assign q_valid  = s_valid;

    assign last_grp = ({1'b0, grp_reg} + 7'd1) == {1'b0, groups_eff};
    assign last_col = ({1'b0, col_reg} + 6'd1) == width_eff;
    assign last_row = ({1'b0, row_reg} + 6'd1) == height_eff;

    always_comb begin
        q_desc.pixels     = s_pixels;
        q_desc.col        = col_reg;
        q_desc.grp        = grp_reg;
        q_desc.emit       = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2))
                            && !row_reg[0] && !col_reg[0];
        q_desc.frame_last = (({1'b0, row_reg} + 6'd2) >= height_eff)
                            && (({1'b0, col_reg} + 6'd2) >= width_eff) && last_grp;
    end

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        grp_next = grp_reg;
        if (cfg_hit) begin
            row_next = '0;
            col_next = '0;
            grp_next = '0;
        end else if (accept) begin
            if (last_grp) begin
                grp_next = '0;
                if (last_col) begin
                    col_next = '0;
                    row_next = last_row ? '0 : row_reg + ROW_W'(1);
                end else begin
                    col_next = col_reg + COL_W'(1);
                end
            end else begin
                grp_next = grp_reg + GRP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_RESET;
            width_reg  <= WIDTH_RESET;
            groups_reg <= GROUPS_RESET;
            row_reg    <= '0;
            col_reg    <= '0;
            grp_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_IN_HEIGHT:      height_reg <= cfg_wr_data;
                    CFG_IN_WIDTH:       width_reg  <= cfg_wr_data;
                    CFG_CHANNEL_GROUPS: groups_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            row_reg <= row_next;
            col_reg <= col_next;
            grp_reg <= grp_next;
        end
    end

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (row_reg == '0 && col_reg == '0 && grp_reg == '0))
        else $error("frame position not restarted by register write");

    a_pos_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, row_reg} < height_eff) && ({1'b0, col_reg} < width_eff)
        && (grp_reg < groups_eff))
        else $error("frame position outside the configured map");

endmodule

`default_nettype wire

@@ rtl/core/mp3s2_queue.sv @@
// Short item queue between the front end and the pooling back end.
`timescale 1ns / 1ps
`default_nettype none

module mp3s2_queue
    import mp3s2_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        in_valid,
    output logic       in_ready,
    input  wire desc_t in_desc,
    output logic       out_valid,
    input  wire        out_ready,
    output desc_t      out_desc
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_desc  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_desc;
        end
    end

    a_ptr_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg == '0) || (count_reg == CNT_W'(QUEUE_DEPTH)))
        == (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

@@ rtl/core/mp3s2_back.sv @@
// Back end: line and column stores, forwarding, 3x3 lane maximum and result register.
`timescale 1ns / 1ps
`default_nettype none

module mp3s2_back
    import mp3s2_pkg::*;
#(
    parameter int LANES      = 8,
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_GROUPS = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                q_valid,
    output logic               q_ready,
    input  wire desc_t         q_desc,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [DATA_W-1:0]  m_pooled,
    output logic               m_frame_last
);

    localparam int DW         = LANES * 8;
    localparam int WMAX       = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam int LINE_DEPTH = WMAX * MAX_GROUPS;
    localparam int LAW        = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int HAW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    desc_t           b2_desc_reg;
    logic            b2_valid_reg;
    logic [LAW-1:0]  b1_line_addr, b2_line_addr_reg;
    logic [HAW-1:0]  b1_hist_addr, b2_hist_addr_reg;
    logic [2*DW-1:0] line_rdata, hist_rdata, line_word, hist_word;
    logic [2*DW-1:0] line_wdata, hist_wdata;
    logic [2*DW-1:0] fwd_line_data_reg, fwd_hist_data_reg;
    logic            fwd_line_reg, fwd_hist_reg;
    logic            out_free, b2_fire, b1_pop;
    logic [DW-1:0]   pix, above1, above2, prev1, prev2, vcol, pooled;
    logic            m_valid_reg, m_frame_last_reg;
    logic [DW-1:0]   m_pooled_reg;

    // Line store word: low half one row back, high half two rows back.
    // Column history word: low half one column back, high half two back.
    assign b1_line_addr = LAW'(int'(q_desc.col) * MAX_GROUPS + int'(q_desc.grp));
    assign b1_hist_addr = HAW'(q_desc.grp);

    assign out_free = !m_valid_reg || m_ready;
    assign b2_fire  = b2_valid_reg && (!b2_desc_reg.emit || out_free);
    assign q_ready  = !b2_valid_reg || b2_fire;
    assign b1_pop   = q_valid && q_ready;

    mp3s2_ram #(.WIDTH(2 * DW), .DEPTH(LINE_DEPTH)) u_line_store (
        .aclk    (aclk),
        .wr_en   (b2_fire),
        .wr_addr (b2_line_addr_reg),
        .wr_data (line_wdata),
        .rd_en   (b1_pop),
        .rd_addr (b1_line_addr),
        .rd_data (line_rdata)
    );

    mp3s2_ram #(.WIDTH(2 * DW), .DEPTH(MAX_GROUPS)) u_col_hist (
        .aclk    (aclk),
        .wr_en   (b2_fire),
        .wr_addr (b2_hist_addr_reg),
        .wr_data (hist_wdata),
        .rd_en   (b1_pop),
        .rd_addr (b1_hist_addr),
        .rd_data (hist_rdata)
    );

    // Back-to-back items on the same entry: take the word just written.
    always_comb begin
        line_word = fwd_line_reg ? fwd_line_data_reg : line_rdata;
        hist_word = fwd_hist_reg ? fwd_hist_data_reg : hist_rdata;
        pix    = b2_desc_reg.pixels[DW-1:0];
        above1 = line_word[DW-1:0];
        above2 = line_word[2*DW-1:DW];
        prev1  = hist_word[DW-1:0];
        prev2  = hist_word[2*DW-1:DW];
        for (int p = 0; p < LANES; p++) begin
            vcol[p*8 +: 8]   = max8(max8(pix[p*8 +: 8], above1[p*8 +: 8]),
                                    above2[p*8 +: 8]);
            pooled[p*8 +: 8] = max8(max8(vcol[p*8 +: 8], prev1[p*8 +: 8]),
                                    prev2[p*8 +: 8]);
        end
        line_wdata = {above1, pix};
        hist_wdata = {prev1, vcol};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
            fwd_line_reg <= 1'b0;
            fwd_hist_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (b1_pop) begin
                b2_valid_reg <= 1'b1;
                fwd_line_reg <= b2_fire && (b1_line_addr == b2_line_addr_reg);
                fwd_hist_reg <= b2_fire && (b1_hist_addr == b2_hist_addr_reg);
            end else if (b2_fire) begin
                b2_valid_reg <= 1'b0;
            end
            if (b2_fire && b2_desc_reg.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b1_pop) begin
            b2_desc_reg       <= q_desc;
            b2_line_addr_reg  <= b1_line_addr;
            b2_hist_addr_reg  <= b1_hist_addr;
            fwd_line_data_reg <= line_wdata;
            fwd_hist_data_reg <= hist_wdata;
        end
        if (b2_fire && b2_desc_reg.emit) begin
            m_pooled_reg     <= pooled;
            m_frame_last_reg <= b2_desc_reg.frame_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pooled     = DATA_W'(m_pooled_reg);
    assign m_frame_last = m_frame_last_reg;

    a_no_stale_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        (b1_pop && !b2_fire) |=> (!fwd_line_reg && !fwd_hist_reg))
        else $error("forwarding armed without a store write");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_fire && b2_desc_reg.emit) |=> m_valid_reg)
        else $error("pooled result lost");

    a_blocked_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_valid_reg && b2_desc_reg.emit && !out_free)
        |=> (b2_valid_reg && $stable(b2_line_addr_reg) && $stable(b2_hist_addr_reg)))
        else $error("blocked item left the execute stage");

endmodule

`default_nettype wire

@@ rtl/core/max_pool_3x3_stride2_unit.sv @@
// Top level of the streaming 3x3 stride-2 max pooling unit.
//
// Input channel (s_valid/s_ready/s_pixels): one item per word of the map,
// in order row, column, channel group; eight unsigned 8-bit lanes each.
// Result channel (m_valid/m_ready/m_pooled/m_frame_last): one pooled item for
// every word whose row and column are both even and at least 2;
// m_frame_last marks the final pooled item of the map.
// Config port: cfg_wr_en writes cfg_wr_data to in_height (0), in_width (1)
// or channel_groups (2) and restarts the frame; write only while idle.
// Throughput: one item per cycle while the receiver keeps up, set by the single
// read and single write port of each store, both used once per item.
// Path: an accepted input passes the queue, the store read and the max tree
// into the output register.
// Reset: registers return to 27 x 27 x 32 groups, position to the first
// word; store contents stay undefined until the first frame writes them.
// Receiver stall: the output register holds the item, the back end stops at the
// next item that pools, the two-entry queue fills and s_ready then drops.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_3x3_stride2_unit
    import mp3s2_pkg::*;
#(
    parameter int LANES      = 8,
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_GROUPS = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [CFG_W-1:0]     cfg_wr_data,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire [DATA_W-1:0]    s_pixels,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic [DATA_W-1:0]   m_pooled,
    output logic                m_frame_last
);

    // Front -> queue
    desc_t fq_desc;
    logic  fq_valid, fq_ready;
    // Queue -> back
    desc_t qb_desc;
    logic  qb_valid, qb_ready;

    // Front: counts the position and tags each item (emits? last?).
    mp3s2_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixels    (s_pixels),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_desc      (fq_desc)
    );

    // Decouples acceptance from back-end stalls.
    mp3s2_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_desc   (fq_desc),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_desc  (qb_desc)
    );

    // Back: store read, vertical then horizontal maxima, store update.
    mp3s2_back #(
        .LANES      (LANES),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_GROUPS (MAX_GROUPS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (qb_valid),
        .q_ready      (qb_ready),
        .q_desc       (qb_desc),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pooled     (m_pooled),
        .m_frame_last (m_frame_last)
    );

endmodule

`default_nettype wire

@@ test/pool_result_checker.sv @@
// Checker for the 3x3 stride-2 max pooling unit: watches both channels, predicts, compares.
`timescale 1ns / 1ps

module pool_result_checker
    import mp3s2_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_GROUPS = 32
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire [CFG_IDX_W-1:0] cfg_index,
    input  wire [CFG_W-1:0]     cfg_wr_data,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  wire [DATA_W-1:0]    s_pixels,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  wire [DATA_W-1:0]    m_pooled,
    input  wire                 m_frame_last,
    output int                  fail_count,
    output int                  results_owed
);

    localparam int WIDTH_CAP  = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
    localparam int HEIGHT_CAP = 32;

    typedef struct packed {
        logic [DATA_W-1:0] pooled;
        logic              frame_last;
    } pooled_word_t;

    pooled_word_t      owed_q[$];
    pooled_word_t      oldest;

    logic [DATA_W-1:0] line_one_back [MAX_WIDTH*MAX_GROUPS];
    logic [DATA_W-1:0] line_two_back [MAX_WIDTH*MAX_GROUPS];
    logic [DATA_W-1:0] column_maxima [2*MAX_GROUPS];

    logic [CFG_W-1:0]  height_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  groups_reg;
    int unsigned       row_pos;
    int unsigned       col_pos;
    int unsigned       grp_pos;

    function automatic logic [DATA_W-1:0] lanewise_max(input logic [DATA_W-1:0] a,
                                                       input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        int                p;
        r = '0;
        for (p = 0; p < 8; p++) begin
            r[p*8 +: 8] = (a[p*8 +: 8] > b[p*8 +: 8]) ? a[p*8 +: 8] : b[p*8 +: 8];
        end
        return r;
    endfunction

    // zero reads as one, large values saturate
    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                              input int unsigned cap);
        if (v == 0) begin
            return 1;
        end
        if (v > cap) begin
            return cap;
        end
        return v;
    endfunction

    task automatic take_item(input logic [DATA_W-1:0] px);
        int unsigned       h, w, gs, r, c, g, li, hi;
        logic [DATA_W-1:0] up1, up2, vcol, left1, left2;
        pooled_word_t      want;
        h  = clamp_dim(height_reg, HEIGHT_CAP);
        w  = clamp_dim(width_reg, WIDTH_CAP);
        gs = clamp_dim(groups_reg, MAX_GROUPS);
        r  = (row_pos >= h) ? 0 : row_pos;
        c  = (col_pos >= w) ? 0 : col_pos;
        g  = (grp_pos >= gs) ? 0 : grp_pos;
        li = c * MAX_GROUPS + g;
        hi = g * 2;

        up1   = line_one_back[li];
        up2   = line_two_back[li];
        vcol  = lanewise_max(lanewise_max(px, up1), up2);
        left1 = column_maxima[hi];
        left2 = column_maxima[hi+1];

        if (r >= 2 && c >= 2 && r % 2 == 0 && c % 2 == 0) begin
            want.pooled     = lanewise_max(lanewise_max(vcol, left1), left2);
            want.frame_last = (r + 2 >= h) && (c + 2 >= w) && (g + 1 == gs);
            owed_q.push_back(want);
        end

        line_two_back[li]  = up1;
        line_one_back[li]  = px;
        column_maxima[hi+1] = left1;
        column_maxima[hi]   = vcol;

        g++;
        if (g >= gs) begin
            g = 0;
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) begin
                    r = 0;
                end
            end
        end
        row_pos = r;
        col_pos = c;
        grp_pos = g;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            height_reg = HEIGHT_RESET;
            width_reg  = WIDTH_RESET;
            groups_reg = GROUPS_RESET;
            row_pos    = 0;
            col_pos    = 0;
            grp_pos    = 0;
            owed_q.delete();
        end else begin
            // results first, so a result never meets an expectation queued this edge
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $error("unexpected item: pooled %h frame_last %b", m_pooled, m_frame_last);
                    fail_count++;
                end else begin
                    oldest = owed_q.pop_front();
                    if (m_pooled !== oldest.pooled) begin
                        $error("pooled: expected %h, actual %h", oldest.pooled, m_pooled);
                        fail_count++;
                    end
                    if (m_frame_last !== oldest.frame_last) begin
                        $error("frame_last: expected %b, actual %b",
                               oldest.frame_last, m_frame_last);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IN_HEIGHT: begin
                        height_reg = cfg_wr_data;
                    end
                    CFG_IN_WIDTH: begin
                        width_reg = cfg_wr_data;
                    end
                    CFG_CHANNEL_GROUPS: begin
                        groups_reg = cfg_wr_data;
                    end
                    default: begin
                    end
                endcase
                if (cfg_index == CFG_IN_HEIGHT || cfg_index == CFG_IN_WIDTH ||
                    cfg_index == CFG_CHANNEL_GROUPS) begin
                    row_pos = 0;
                    col_pos = 0;
                    grp_pos = 0;
                end
            end
            if (s_valid && s_ready) begin
                take_item(s_pixels);
            end
        end
        results_owed = owed_q.size();
    end

endmodule

@@ test/tb_max_pool_3x3_stride2_unit.sv @@
// Testbench top for the 3x3 stride-2 max pooling unit: stimulus, pacing and verdict.
`timescale 1ns / 1ps

module tb_max_pool_3x3_stride2_unit;
    import mp3s2_pkg::*;

    // Index 3 is outside the register map; a write there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNUSED = 2'd3;

    // Pacing modes for a phase
    localparam int PACE_FREE           = 0;
    localparam int PACE_SLOW_SENDER    = 1;
    localparam int PACE_SLOW_RECEIVER  = 2;
    localparam int PACE_BOTH           = 3;

    // Room for the two-entry queue and the back-end registers to empty, with margin.
    localparam int DRAIN_CYCLES = 8;
    // Long enough for the queue to fill and s_ready to drop.
    localparam int LONG_HOLD    = 60;
    // Timeout in ns, at a 4 ns clock period.
    localparam int TIMEOUT_NS   = 2_000_000;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [DATA_W-1:0]    s_pixels    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [DATA_W-1:0]    m_pooled;
    logic                 m_frame_last;

    int                   fail_count;
    int                   results_owed;

    // pacing knobs, per cent per cycle
    int                   idle_pct      = 0;
    int                   stall_pct     = 0;
    // long hold-off: the stimulus bumps the request count, the receiver counts it out
    int                   hold_requests = 0;
    int                   hold_seen     = 0;
    int                   hold_left     = 0;

    max_pool_3x3_stride2_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixels     (s_pixels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pooled     (m_pooled),
        .m_frame_last (m_frame_last)
    );

    pool_result_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixels     (s_pixels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pooled     (m_pooled),
        .m_frame_last (m_frame_last),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one item and return at the edge that accepts it. Valid stays high
    // on return, so back-to-back items never drop it within one time step.
    task automatic offer_item(input logic [DATA_W-1:0] px);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_pixels <= px;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic offer_items(input int n);
        repeat (n) begin
            offer_item(random_word());
        end
    endtask

    // Stop sending, wait for every owed result, then let the block go quiet;
    // items that pool to nothing may still be in flight when the last result lands.
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_owed != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Only ever called with the block idle.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_map(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w,
                           input logic [CFG_W-1:0] g);
        cfg_write(CFG_IN_HEIGHT, h);
        cfg_write(CFG_IN_WIDTH, w);
        cfg_write(CFG_CHANNEL_GROUPS, g);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] w,
                             input logic [CFG_W-1:0] g, input int n, input int pace);
        settle();
        set_map(h, w, g);
        case (pace)
            PACE_SLOW_SENDER: begin
                idle_pct  = 66;
                stall_pct = 0;
            end
            PACE_SLOW_RECEIVER: begin
                idle_pct  = 0;
                stall_pct = 66;
            end
            PACE_BOTH: begin
                idle_pct  = 7;
                stall_pct = 7;
            end
            default: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
        endcase
        offer_items(n);
    endtask

    initial begin
        logic [DATA_W-1:0] corner_words [18];
        int                k;

        // Frame one: word k peaks in lane k mod 8, so every window position but the
        // first feeds some lane of the single pooled item (word 8 wins lane 0).
        for (k = 0; k < 9; k++) begin
            corner_words[k] = {8{8'(k)}};
            corner_words[k][(k%8)*8 +: 8] = 8'hF0 + 8'(k);
        end
        // Frame two: field extremes and lane patterns
        corner_words[9]  = 64'h0000_0000_0000_0000;
        corner_words[10] = 64'hFFFF_FFFF_FFFF_FFFF;
        corner_words[11] = 64'hFF00_FF00_FF00_FF00;
        corner_words[12] = 64'h00FF_00FF_00FF_00FF;
        corner_words[13] = 64'h8080_8080_8080_8080;
        corner_words[14] = 64'h7F7F_7F7F_7F7F_7F7F;
        corner_words[15] = 64'h0123_4567_89AB_CDEF;
        corner_words[16] = 64'hFEDC_BA98_7654_3210;
        corner_words[17] = 64'h0101_0101_0101_0101;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: two 3x3 maps of one group, one pooled item each,
        // which is also the frame's last
        set_map(3, 3, 1);
        for (k = 0; k < 18; k++) begin
            offer_item(corner_words[k]);
        end

        // Small maps under free and slow-sender pacing; the first one wraps over a frame end
        run_phase(5, 5, 2, 60, PACE_FREE);
        run_phase(7, 4, 3, 36, PACE_SLOW_SENDER);

        // Extremes of the map: width given out of range saturates to 32, one
        // full frame; then height out of range saturates to 32, a full frame
        // and the start of the next one
        run_phase(3, 33, 1, 96, PACE_SLOW_RECEIVER);
        run_phase(33, 3, 1, 105, PACE_BOTH);

        // Back-pressure: receiver holds off while the sender keeps offering,
        // so the queue fills and s_ready drops
        run_phase(6, 6, 1, 10, PACE_FREE);
        hold_requests <= hold_requests + 1;
        offer_items(40);

        // Out-of-range and too-small maps: no pooled items at all
        run_phase(0, 63, 0, 12, PACE_SLOW_SENDER);
        run_phase(63, 0, 33, 12, PACE_BOTH);
        run_phase(2, 5, 1, 12, PACE_FREE);

        // A register write part-way through a map restarts the frame
        run_phase(5, 5, 1, 17, PACE_FREE);
        settle();
        cfg_write(CFG_IN_WIDTH, 5);
        offer_items(30);

        // A write beyond the register map leaves the position alone
        run_phase(5, 5, 1, 12, PACE_SLOW_RECEIVER);
        settle();
        cfg_write(CFG_INDEX_UNUSED, 6'($urandom_range(63)));
        offer_items(20);

        // Random small maps, rotating through the first two pacing modes
        for (k = 0; k < 2; k++) begin
            run_phase(6'($urandom_range(3, 5)), 6'($urandom_range(3, 5)),
                      6'($urandom_range(1, 2)), $urandom_range(20, 40), k % 4);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ max_pool_3x3_stride2_unit.f @@
rtl/core/mp3s2_pkg.sv
rtl/core/mp3s2_ram.sv
rtl/core/mp3s2_front.sv
rtl/core/mp3s2_queue.sv
rtl/core/mp3s2_back.sv
rtl/core/max_pool_3x3_stride2_unit.sv
test/pool_result_checker.sv
test/tb_max_pool_3x3_stride2_unit.sv
